// ===== sv/dblp_pkg.sv =====
package dblp_pkg;

  localparam int DIV_W = 32;
  localparam int PER_W = 20;
  localparam int STP_W = 10;
  localparam int LVL_W = 8;
  localparam int UPT_W = 32;
  localparam int ADDR_W = 4;

  localparam logic [UPT_W-1:0] STRIP_INTERVAL = 32'd15000;
  localparam logic [LVL_W-1:0] LEVEL_ONE_OFF = 8'd128;

  typedef enum logic [1:0] {
    REG_PERIOD_ONE = 2'd0,
    REG_STEPS_ONE  = 2'd1,
    REG_PERIOD_TWO = 2'd2,
    REG_STEPS_TWO  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [PER_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
    logic [PER_W-1:0] rem;
  } div_rsp_t;

endpackage

// ===== sv/dblp_div.sv =====
module dblp_div
  import dblp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIV_W);

  logic [DIV_W-1:0] dvd_r;
  logic [PER_W-1:0] rem_r;
  logic [PER_W-1:0] dsr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  // one quotient bit per cycle, restoring
  logic [PER_W:0] rem_sh;
  logic [PER_W:0] rem_sub;
  logic           ge;

  assign rem_sh  = {rem_r, dvd_r[DIV_W-1]};
  assign rem_sub = rem_sh - {1'b0, dsr_r};
  assign ge      = (rem_sh >= {1'b0, dsr_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !req.start && busy_r && (cnt_r == '0);
      if (req.start) begin
        dvd_r  <= req.dividend;
        dsr_r  <= req.divisor;
        rem_r  <= '0;
        cnt_r  <= CNT_W'(DIV_W - 1);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? rem_sub[PER_W-1:0] : rem_sh[PER_W-1:0];
        dvd_r <= {dvd_r[DIV_W-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = dvd_r;
  assign rsp.rem  = rem_r;

endmodule

// ===== sv/dual_breathing_led_pwm.sv =====
// channel   handshake                      payload
// in_       in_valid / in_stall            in_elapsed_us
// out_      out_valid / out_stall          out_led_one_on, out_led_two_on, out_level_one,
//                                          out_level_two, out_strip_update
// apb       psel penable pwrite pready     paddr, pwdata, prdata
//
// one item at a time: after the strip check, each enabled channel takes four passes of the
// shared bit-serial divider: uptime by period, that quotient by steps, period times step by
// steps and 255 times duty by period; a disabled channel gets its fixed outputs instead;
// the result is then loaded into the output register and the next item is taken in idle
// the single 32-bit restoring divider does every one of these divides
// rst_n is synchronous: uptime, strip time and registers go to their reset values
// in_stall is high while an item is at work; the result sits in the output register
// so the next item is taken while the result still waits on out_stall
module dual_breathing_led_pwm
  import dblp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [PER_W-1:0]  in_elapsed_us,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_led_one_on,
  output logic              out_led_two_on,
  output logic [LVL_W-1:0]  out_level_one,
  output logic [LVL_W-1:0]  out_level_two,
  output logic              out_strip_update,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_STRIP, S_CH, S_D1, S_D2, S_MUL, S_D3, S_LVL, S_D4, S_FIN
  } state_t;

  state_t state_r;

  // configuration registers
  logic [PER_W-1:0] period_one_r, period_two_r;
  logic [STP_W-1:0] steps_one_r, steps_two_r;

  // block state
  logic [UPT_W-1:0] uptime_r;
  logic [UPT_W-1:0] last_r;
  logic             strip_r;
  logic             ch_r;

  // per-item working registers
  logic [PER_W-1:0] r_r;       // uptime mod period
  logic [STP_W-1:0] step_r;
  logic             odd_r;     // sweep count odd
  logic [PER_W-1:0] duty_r;
  logic             on1_r, on2_r;
  logic [LVL_W-1:0] lvl1_r, lvl2_r;

  // output register
  logic             out_valid_r;
  logic             on1_out_r, on2_out_r, strip_out_r;
  logic [LVL_W-1:0] lvl1_out_r, lvl2_out_r;

  div_req_t req_r;
  div_rsp_t rsp;

  dblp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req_r),
    .rsp   (rsp)
  );

  // apb
  logic     wr_en;
  reg_idx_t widx;
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign widx   = reg_idx_t'(paddr[3:2]);

  always_comb begin
    unique case (widx)
      REG_PERIOD_ONE: prdata = {12'd0, period_one_r};
      REG_STEPS_ONE:  prdata = {22'd0, steps_one_r};
      REG_PERIOD_TWO: prdata = {12'd0, period_two_r};
      REG_STEPS_TWO:  prdata = {22'd0, steps_two_r};
      default:        prdata = '0;
    endcase
  end

  // active channel operands, zero steps reads as one
  logic [PER_W-1:0] per_c;
  logic [STP_W-1:0] stp_raw, stp_c;
  assign per_c   = ch_r ? period_two_r : period_one_r;
  assign stp_raw = ch_r ? steps_two_r : steps_one_r;
  assign stp_c   = (stp_raw == '0) ? STP_W'(1) : stp_raw;

  logic [UPT_W-1:0] since;
  assign since = uptime_r - last_r;

  // period times step stays below 2^30
  logic [PER_W+STP_W-1:0] prod;
  assign prod = per_c * step_r;

  logic [PER_W-1:0] duty_m;
  assign duty_m = odd_r ? (per_c - rsp.quo[PER_W-1:0]) : rsp.quo[PER_W-1:0];

  // 255 * duty as duty * 256 - duty
  logic [PER_W+LVL_W-1:0] lvl_num;
  assign lvl_num = {duty_r, {LVL_W{1'b0}}} - {{LVL_W{1'b0}}, duty_r};

  logic out_free;
  assign out_free = !out_valid_r || !out_stall;

  // divider start pulse for the states that launch a pass
  logic start_nxt;
  assign start_nxt = (state_r == S_CH && per_c != '0) || (state_r == S_D1 && rsp.done) ||
                     (state_r == S_MUL) || (state_r == S_LVL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      period_one_r <= '0;
      period_two_r <= '0;
      steps_one_r  <= STP_W'(1);
      steps_two_r  <= STP_W'(1);
      uptime_r     <= '0;
      last_r       <= '0;
      out_valid_r  <= 1'b0;
      req_r.start  <= 1'b0;
      ch_r         <= 1'b0;
    end else begin
      req_r.start <= start_nxt;

      if (wr_en) begin
        unique case (widx)
          REG_PERIOD_ONE: period_one_r <= pwdata[PER_W-1:0];
          REG_STEPS_ONE:  steps_one_r  <= pwdata[STP_W-1:0];
          REG_PERIOD_TWO: period_two_r <= pwdata[PER_W-1:0];
          REG_STEPS_TWO:  steps_two_r  <= pwdata[STP_W-1:0];
          default: ;
        endcase
      end

      if (state_r == S_FIN && out_free) out_valid_r <= 1'b1;
      else if (!out_stall)              out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            uptime_r <= uptime_r + {{(UPT_W-PER_W){1'b0}}, in_elapsed_us};
            state_r  <= S_STRIP;
          end
        end
        S_STRIP: begin
          strip_r <= (since >= STRIP_INTERVAL);
          if (since >= STRIP_INTERVAL) last_r <= uptime_r;
          ch_r    <= 1'b0;
          state_r <= S_CH;
        end
        S_CH: begin
          if (per_c == '0) begin
            // disabled channel: one forced on at mid level, two forced off
            if (ch_r) begin
              on2_r   <= 1'b0;
              lvl2_r  <= '0;
              state_r <= S_FIN;
            end else begin
              on1_r  <= 1'b1;
              lvl1_r <= LEVEL_ONE_OFF;
              ch_r   <= 1'b1;
            end
          end else begin
            req_r.dividend <= uptime_r;
            req_r.divisor  <= per_c;
            state_r        <= S_D1;
          end
        end
        S_D1: begin
          if (rsp.done) begin
            r_r            <= rsp.rem;
            req_r.dividend <= rsp.quo;
            req_r.divisor  <= {{(PER_W-STP_W){1'b0}}, stp_c};
            state_r        <= S_D2;
          end
        end
        S_D2: begin
          if (rsp.done) begin
            step_r  <= rsp.rem[STP_W-1:0];
            odd_r   <= rsp.quo[0];
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          req_r.dividend <= {{(DIV_W-PER_W-STP_W){1'b0}}, prod};
          req_r.divisor  <= {{(PER_W-STP_W){1'b0}}, stp_c};
          state_r        <= S_D3;
        end
        S_D3: begin
          if (rsp.done) begin
            duty_r  <= duty_m;
            state_r <= S_LVL;
          end
        end
        S_LVL: begin
          if (ch_r) on2_r <= (r_r > duty_r);
          else      on1_r <= (r_r > duty_r);
          req_r.dividend <= {{(DIV_W-PER_W-LVL_W){1'b0}}, lvl_num};
          req_r.divisor  <= per_c;
          state_r        <= S_D4;
        end
        S_D4: begin
          if (rsp.done) begin
            if (ch_r) begin
              lvl2_r  <= rsp.quo[LVL_W-1:0];
              state_r <= S_FIN;
            end else begin
              lvl1_r  <= rsp.quo[LVL_W-1:0];
              ch_r    <= 1'b1;
              state_r <= S_CH;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result payload, loaded as the item completes
  always_ff @(posedge clk) begin
    if (state_r == S_FIN && out_free) begin
      on1_out_r   <= on1_r;
      on2_out_r   <= on2_r;
      lvl1_out_r  <= lvl1_r;
      lvl2_out_r  <= lvl2_r;
      strip_out_r <= strip_r;
    end
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_led_one_on   = on1_out_r;
  assign out_led_two_on   = on2_out_r;
  assign out_level_one    = lvl1_out_r;
  assign out_level_two    = lvl2_out_r;
  assign out_strip_update = strip_out_r;

`ifndef SYNTHESIS
  a_accept_strip: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_STRIP))
    else $error("accepted item did not enter strip check");

  a_strip_time: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && strip_r) |-> (last_r == uptime_r))
    else $error("strip refresh time not recorded");

  a_one_off_level: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && period_one_r == '0) |-> (on1_r && lvl1_r == LEVEL_ONE_OFF))
    else $error("disabled channel one not forced");
`endif

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import dblp_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [PER_W-1:0]  in_elapsed_us = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_led_one_on;
  logic              out_led_two_on;
  logic [LVL_W-1:0]  out_level_one;
  logic [LVL_W-1:0]  out_level_two;
  logic              out_strip_update;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  dual_breathing_led_pwm DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one expected output item
  typedef struct packed {
    logic             led_one;
    logic             led_two;
    logic [LVL_W-1:0] lvl_one;
    logic [LVL_W-1:0] lvl_two;
    logic             strip;
  } led_frame_t;

  // a row of the directed table: 0 = tick, 1 = register write
  typedef struct {
    bit              is_cfg;
    reg_idx_t        reg_sel;
    logic [31:0]     value;
    bit              has_fixed;
    led_frame_t      fixed;
  } stim_row_t;

  led_frame_t  frame_q[$];
  int          errors = 0;
  int          cycles = 0;
  bit          quiet = 1'b0;   // no idling in the last part

  // local copy of the block state
  logic [31:0] m_period_one, m_steps_one, m_period_two, m_steps_two;
  logic [31:0] m_uptime, m_last_strip;

  // one channel; returns led state, writes level
  function automatic logic sweep_channel(input logic [31:0] per, input logic [31:0] stp,
                                         input logic [31:0] now,
                                         output logic [LVL_W-1:0] lvl);
    logic [31:0] s, step, duty, sweep, l;
    s = (stp == 0) ? 32'd1 : stp;
    step = (now / per) % s;
    duty = (per * step) / s;
    sweep = now / (per * s);
    if (sweep[0]) duty = per - duty;
    l = (32'd255 * duty) / per;
    lvl = l[LVL_W-1:0];
    return (now % per) > duty;
  endfunction

  function automatic led_frame_t advance_uptime(input logic [PER_W-1:0] el);
    led_frame_t f;
    m_uptime = m_uptime + 32'(el);
    f.led_one = 1'b1;
    f.lvl_one = LEVEL_ONE_OFF;
    f.led_two = 1'b0;
    f.lvl_two = '0;
    f.strip = 1'b0;
    if (m_period_one != 0)
      f.led_one = sweep_channel(m_period_one, m_steps_one, m_uptime, f.lvl_one);
    if (m_period_two != 0)
      f.led_two = sweep_channel(m_period_two, m_steps_two, m_uptime, f.lvl_two);
    if (m_uptime - m_last_strip >= STRIP_INTERVAL) begin
      m_last_strip = m_uptime;
      f.strip = 1'b1;
    end
    return f;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: random stall bursts
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 11);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  // compare each accepted item with the oldest expectation
  always @(posedge clk) begin
    led_frame_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (frame_q.size() == 0) begin
        $error("output item with nothing expected");
        errors++;
      end else begin
        e = frame_q.pop_front();
        if (out_led_one_on !== e.led_one) begin
          $error("led_one_on exp %0d got %0d", e.led_one, out_led_one_on); errors++;
        end
        if (out_led_two_on !== e.led_two) begin
          $error("led_two_on exp %0d got %0d", e.led_two, out_led_two_on); errors++;
        end
        if (out_level_one !== e.lvl_one) begin
          $error("level_one exp %0d got %0d", e.lvl_one, out_level_one); errors++;
        end
        if (out_level_two !== e.lvl_two) begin
          $error("level_two exp %0d got %0d", e.lvl_two, out_level_two); errors++;
        end
        if (out_strip_update !== e.strip) begin
          $error("strip_update exp %0d got %0d", e.strip, out_strip_update); errors++;
        end
      end
    end
  end

  task automatic cfg_write(input reg_idx_t r, input logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * int'(r));
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (r)
      REG_PERIOD_ONE: m_period_one = v & 32'hFFFFF;
      REG_STEPS_ONE:  m_steps_one = v & 32'h3FF;
      REG_PERIOD_TWO: m_period_two = v & 32'hFFFFF;
      default:        m_steps_two = v & 32'h3FF;
    endcase
  endtask

  // wait for every expected item, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic send_tick(input logic [PER_W-1:0] el, input bit has_fixed,
                           input led_frame_t fixed);
    led_frame_t f;
    int n;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_elapsed_us <= el;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    f = advance_uptime(el);
    if (has_fixed && f !== fixed) begin
      $error("directed row disagrees with prediction");
      errors++;
    end
    frame_q.push_back(has_fixed ? fixed : f);
  endtask

  function automatic stim_row_t tick_row(input logic [31:0] el, input bit fx,
                                         input led_frame_t f);
    stim_row_t r;
    r.is_cfg = 1'b0; r.reg_sel = REG_PERIOD_ONE; r.value = el;
    r.has_fixed = fx; r.fixed = f;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input reg_idx_t s, input logic [31:0] v);
    stim_row_t r;
    r.is_cfg = 1'b1; r.reg_sel = s; r.value = v; r.has_fixed = 1'b0; r.fixed = '0;
    return r;
  endfunction

  initial begin
    stim_row_t rows[$];
    logic [31:0] p1, p2;
    m_period_one = 0; m_steps_one = 1; m_period_two = 0; m_steps_two = 1;
    m_uptime = 0; m_last_strip = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // both channels off after reset: fixed levels, strip at 15000 boundary
    rows.push_back(tick_row(32'd0, 1'b1, '{1'b1, 1'b0, 8'd128, 8'd0, 1'b0}));
    rows.push_back(tick_row(32'd14999, 1'b1, '{1'b1, 1'b0, 8'd128, 8'd0, 1'b0}));
    rows.push_back(tick_row(32'd1, 1'b1, '{1'b1, 1'b0, 8'd128, 8'd0, 1'b1}));
    rows.push_back(tick_row(32'hFFFFF, 1'b1, '{1'b1, 1'b0, 8'd128, 8'd0, 1'b1}));
    rows.push_back(cfg_row(REG_PERIOD_ONE, 1000));
    rows.push_back(cfg_row(REG_STEPS_ONE, 10));
    rows.push_back(cfg_row(REG_PERIOD_TWO, 20'hFFFFF));
    rows.push_back(cfg_row(REG_STEPS_TWO, 1023));
    for (int i = 0; i < 6; i++) rows.push_back(tick_row(32'(137 * i + 1), 1'b0, '0));
    // steps zero acts as one
    rows.push_back(cfg_row(REG_STEPS_ONE, 0));
    rows.push_back(cfg_row(REG_PERIOD_TWO, 1));
    rows.push_back(cfg_row(REG_STEPS_TWO, 1));
    for (int i = 0; i < 4; i++) rows.push_back(tick_row(32'(20'hFFFFF - i), 1'b0, '0));
    // a run of longest ticks, with random gaps between them
    for (int i = 0; i < 60; i++) rows.push_back(tick_row(32'hFFFFF, 1'b0, '0));

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        drain();
        cfg_write(rows[i].reg_sel, rows[i].value);
      end else
        send_tick(rows[i].value[PER_W-1:0], rows[i].has_fixed, rows[i].fixed);
    end

    // random phases with fresh settings, extremes mixed in
    for (int ph = 0; ph < 15; ph++) begin
      drain();
      case ($urandom_range(0, 3))
        0: p1 = 0;
        1: p1 = 20'hFFFFF;
        2: p1 = $urandom_range(1, 50);
        default: p1 = $urandom_range(1, 20'hFFFFF);
      endcase
      case ($urandom_range(0, 3))
        0: p2 = 0;
        1: p2 = 20'hFFFFF;
        2: p2 = $urandom_range(1, 50);
        default: p2 = $urandom_range(1, 20'hFFFFF);
      endcase
      cfg_write(REG_PERIOD_ONE, p1);
      cfg_write(REG_STEPS_ONE, ($urandom_range(0, 3) == 0) ? 1023 : $urandom_range(0, 1023));
      cfg_write(REG_PERIOD_TWO, p2);
      cfg_write(REG_STEPS_TWO, ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(0, 1023));
      if (ph == 13) quiet = 1'b1;
      for (int k = 0; k < 100; k++) begin
        case ($urandom_range(0, 3))
          0: send_tick(PER_W'($urandom_range(0, 20'hFFFFF)), 1'b0, '0);
          1: send_tick(PER_W'($urandom_range(0, 100)), 1'b0, '0);
          2: send_tick(PER_W'($urandom_range(14990, 15010)), 1'b0, '0);
          default: send_tick(($urandom_range(0, 1)) ? 20'hFFFFF : 20'h0, 1'b0, '0);
        endcase
      end
    end

    drain();
    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
